@@ rtl/c128_pkg.sv @@
// shared types, codeword constants, bar pattern table and mod-103 reduction
// for the code 128 symbol encoder; no dependencies
package c128_pkg;

  localparam int LOOKAHEAD = 4;
  localparam int FILL_W = $clog2(LOOKAHEAD + 1);

  localparam logic [6:0] CW_SW_C    = 7'd99;
  localparam logic [6:0] CW_SW_B    = 7'd100;
  localparam logic [6:0] CW_SW_A    = 7'd101;
  localparam logic [6:0] CW_START_A = 7'd103;
  localparam logic [6:0] CW_START_B = 7'd104;
  localparam logic [6:0] CW_START_C = 7'd105;
  localparam logic [6:0] CW_STOP    = 7'd106;
  localparam logic [6:0] CHR_SPACE  = 7'd32;
  localparam logic [6:0] CHR_AT     = 7'd64;
  localparam logic [2:0] STOP_TAIL  = 3'd2;

  typedef enum logic [1:0] {SET_NONE, SET_A, SET_B, SET_C} set_t;

  typedef enum logic [1:0] {ST_FETCH, ST_WORK, ST_CHECK, ST_STOP} state_t;

  // one queued character with its classification
  typedef struct packed {
    logic       err;
    logic       last;
    logic       dig;
    logic [6:0] chr;
  } item_t;

  // each hex digit holds one element width
  localparam logic [23:0] BAR_TABLE [107] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
    24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
    24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
    24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
    24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
    24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
    24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
    24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
    24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
    24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
    24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
    24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
    24'h411131, 24'h211412, 24'h211214, 24'h211232, 24'h233111
  };

  // 128 = 25 mod 103, folded three times then a final correction
  function automatic logic [6:0] mod103(input logic [13:0] x);
    logic [11:0] a;
    logic [9:0]  b;
    logic [7:0]  c;
    a = 12'(x[13:7]) * 12'd25 + 12'(x[6:0]);
    b = 10'(a[11:7]) * 10'd25 + 10'(a[6:0]);
    c = 8'(b[9:7]) * 8'd25 + 8'(b[6:0]);
    if (c >= 8'd206) begin
      return 7'(c - 8'd206);
    end else if (c >= 8'd103) begin
      return 7'(c - 8'd103);
    end
    return c[6:0];
  endfunction

endpackage

@@ rtl/c128_front.sv @@
// front end: classifies incoming bytes and holds them in a two-entry queue
// depends on c128_pkg
module c128_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        character,
  input  logic              last_char,
  input  logic              char_valid,
  output logic              char_ready,
  output c128_pkg::item_t   q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import c128_pkg::*;

  item_t      slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  item_t      incoming;

  assign char_ready = (cnt != 2'd2);
  assign push       = char_valid && char_ready;
  assign q_valid    = (cnt != 2'd0);
  assign q_item     = slot[rp];

  always_comb begin
    incoming.err  = character[7];
    incoming.last = last_char;
    incoming.dig  = (character >= 8'd48) && (character <= 8'd57);
    incoming.chr  = character[6:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ rtl/c128_back.sv @@
// back end: lookahead window, set selection, checksum and output register
// depends on c128_pkg
module c128_back (
  input  logic              clk,
  input  logic              rst,
  input  c128_pkg::item_t   q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output logic [6:0]        codeword,
  output logic [2:0]        bar_one,
  output logic [2:0]        space_one,
  output logic [2:0]        bar_two,
  output logic [2:0]        space_two,
  output logic [2:0]        bar_three,
  output logic [2:0]        space_three,
  output logic [2:0]        final_bar,
  output logic              last_symbol,
  output logic              bad_input,
  output logic              sym_valid,
  input  logic              sym_ready
);
  import c128_pkg::*;

  logic [6:0]           win_chr [LOOKAHEAD];
  logic [LOOKAHEAD-1:0] win_dig;
  logic [FILL_W-1:0]    fill;
  set_t                 cur_set;
  logic [6:0]           pos;
  logic [6:0]           checksum;
  logic                 discarding;
  logic                 msg_last;
  state_t               state;
  state_t               state_next;
  logic                 prod_valid;
  logic [13:0]          prod;

  logic [FILL_W-1:0]    run;
  logic                 run_ok;
  logic                 can_emit;
  logic                 has_start;
  logic                 has_work;
  logic                 fetching;
  set_t                 c0_set;

  logic                 emit;
  logic                 emit_err;
  logic [6:0]           emit_cw;
  logic                 do_weight;
  logic                 do_start;
  logic                 do_clear;
  logic                 do_load;
  logic                 do_cons1;
  logic                 do_cons2;
  logic                 set_load;
  set_t                 set_next;
  logic [23:0]          pat;

  // leading digit run inside the filled part of the window
  always_comb begin
    run    = '0;
    run_ok = 1'b1;
    for (int i = 0; i < LOOKAHEAD; i++) begin
      if (run_ok && (FILL_W'(i) < fill) && win_dig[i]) begin
        run = run + 1'b1;
      end else begin
        run_ok = 1'b0;
      end
    end
  end

  assign can_emit  = !sym_valid || sym_ready;
  assign c0_set    = (win_chr[0] < CHR_SPACE) ? SET_A : SET_B;
  assign has_start = (cur_set == SET_NONE) &&
                     ((int'(fill) >= LOOKAHEAD) || msg_last);
  assign has_work  = msg_last ? (fill != '0) : (int'(fill) >= LOOKAHEAD);
  assign fetching  = (state == ST_FETCH) ||
                     ((state == ST_WORK) && !has_start && !has_work && !msg_last);

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_FETCH, ST_WORK: begin
        if (fetching) begin
          if (q_pop && !discarding && !q_item.err) state_next = ST_WORK;
          else state_next = ST_FETCH;
        end else if (!has_start && !has_work) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!prod_valid && can_emit) state_next = ST_STOP;
      end
      ST_STOP: begin
        if (can_emit) state_next = ST_FETCH;
      end
      default: state_next = ST_FETCH;
    endcase
  end

  // actions
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_err  = 1'b0;
    emit_cw   = '0;
    do_weight = 1'b0;
    do_start  = 1'b0;
    do_clear  = 1'b0;
    do_load   = 1'b0;
    do_cons1  = 1'b0;
    do_cons2  = 1'b0;
    set_load  = 1'b0;
    set_next  = cur_set;
    unique case (state) inside
      ST_FETCH, ST_WORK: begin
        if (fetching) begin
          if (q_valid && (discarding || !q_item.err || can_emit)) begin
            q_pop = 1'b1;
            if (!discarding) begin
              if (q_item.err) begin
                emit     = 1'b1;
                emit_err = 1'b1;
                do_clear = 1'b1;
              end else begin
                do_load = 1'b1;
              end
            end
          end
        end else if (has_start) begin
          if (can_emit) begin
            emit     = 1'b1;
            do_start = 1'b1;
            set_load = 1'b1;
            if ((int'(run) >= 4) || (msg_last && (run == fill))) begin
              set_next = SET_C;
              emit_cw  = CW_START_C;
            end else if (c0_set == SET_A) begin
              set_next = SET_A;
              emit_cw  = CW_START_A;
            end else begin
              set_next = SET_B;
              emit_cw  = CW_START_B;
            end
          end
        end else if (has_work) begin
          if (can_emit) begin
            emit      = 1'b1;
            do_weight = 1'b1;
            if ((cur_set != SET_C) && (int'(run) >= 4)) begin
              set_load = 1'b1;
              set_next = SET_C;
              emit_cw  = CW_SW_C;
            end else if (cur_set == SET_C) begin
              if (int'(run) >= 2) begin
                emit_cw  = 7'(win_chr[0][3:0]) * 7'd10 + 7'(win_chr[1][3:0]);
                do_cons2 = 1'b1;
              end else begin
                set_load = 1'b1;
                set_next = c0_set;
                emit_cw  = (c0_set == SET_A) ? CW_SW_A : CW_SW_B;
              end
            end else if (c0_set != cur_set) begin
              set_load = 1'b1;
              set_next = c0_set;
              emit_cw  = (c0_set == SET_A) ? CW_SW_A : CW_SW_B;
            end else begin
              do_cons1 = 1'b1;
              if ((cur_set == SET_A) && (win_chr[0] < CHR_SPACE)) begin
                emit_cw = win_chr[0] + CHR_AT;
              end else begin
                emit_cw = win_chr[0] - CHR_SPACE;
              end
            end
          end
        end
      end
      ST_CHECK: begin
        if (!prod_valid && can_emit) begin
          emit    = 1'b1;
          emit_cw = checksum;
        end
      end
      ST_STOP: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_cw  = CW_STOP;
          do_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      discarding <= 1'b0;
      msg_last   <= 1'b0;
      cur_set    <= SET_NONE;
      fill       <= '0;
      pos        <= '0;
      checksum   <= '0;
      prod_valid <= 1'b0;
      sym_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        if (discarding) discarding <= !q_item.last;
        else if (q_item.err) discarding <= !q_item.last;
      end
      if (do_load) msg_last <= q_item.last;

      if (do_clear) cur_set <= SET_NONE;
      else if (set_load) cur_set <= set_next;

      if (do_clear) fill <= '0;
      else if (do_load) fill <= fill + 1'b1;
      else if (do_cons1) fill <= fill - 1'b1;
      else if (do_cons2) fill <= fill - FILL_W'(2);

      if (do_clear) begin
        checksum   <= '0;
        pos        <= '0;
        prod_valid <= 1'b0;
      end else if (do_start) begin
        checksum   <= 7'(emit_cw - CW_START_A);
        pos        <= 7'd1;
        prod_valid <= 1'b0;
      end else begin
        if (prod_valid) checksum <= mod103(14'(checksum) + prod);
        prod_valid <= do_weight;
        if (do_weight) pos <= (pos == 7'd102) ? 7'd0 : pos + 7'd1;
      end

      if (emit) sym_valid <= 1'b1;
      else if (sym_ready) sym_valid <= 1'b0;
    end
  end

  // window storage and product register
  always_ff @(posedge clk) begin
    if (do_weight) prod <= 14'(emit_cw) * 14'(pos);
    if (do_load) begin
      win_chr[fill[$clog2(LOOKAHEAD)-1:0]] <= q_item.chr;
      win_dig[fill[$clog2(LOOKAHEAD)-1:0]] <= q_item.dig;
    end else if (do_cons1) begin
      for (int i = 0; i + 1 < LOOKAHEAD; i++) begin
        win_chr[i] <= win_chr[i + 1];
        win_dig[i] <= win_dig[i + 1];
      end
    end else if (do_cons2) begin
      for (int i = 0; i + 2 < LOOKAHEAD; i++) begin
        win_chr[i] <= win_chr[i + 2];
        win_dig[i] <= win_dig[i + 2];
      end
    end
  end

  assign pat = BAR_TABLE[emit_cw];

  always_ff @(posedge clk) begin
    if (emit) begin
      codeword    <= emit_cw;
      bad_input   <= emit_err;
      last_symbol <= emit_err || (emit_cw == CW_STOP);
      final_bar   <= (!emit_err && (emit_cw == CW_STOP)) ? STOP_TAIL : 3'd0;
      if (emit_err) begin
        bar_one     <= '0;
        space_one   <= '0;
        bar_two     <= '0;
        space_two   <= '0;
        bar_three   <= '0;
        space_three <= '0;
      end else begin
        bar_one     <= pat[22:20];
        space_one   <= pat[18:16];
        bar_two     <= pat[14:12];
        space_two   <= pat[10:8];
        bar_three   <= pat[6:4];
        space_three <= pat[2:0];
      end
    end
  end

endmodule

@@ rtl/code128_symbol_encoder.sv @@
// channel | signals                         | direction
// char    | char_valid/char_ready, payload  | in
// sym     | sym_valid/sym_ready, payload    | out
//
// one character enters a two-entry queue per cycle while char_ready is high; the back end
// pops one and emits at most one codeword per cycle, so a plain text character takes
// a pop and then an emit, and a message end adds start, drain, checksum, stop
// reset is synchronous and clears control state; no clearing pass
// the output register takes a new codeword while the old one is transferred
// top level of the code 128 symbol encoder; depends on c128_pkg,
// c128_front and c128_back
module code128_symbol_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] character,
  input  logic       last_char,
  input  logic       char_valid,
  output logic       char_ready,
  output logic [6:0] codeword,
  output logic [2:0] bar_one,
  output logic [2:0] space_one,
  output logic [2:0] bar_two,
  output logic [2:0] space_two,
  output logic [2:0] bar_three,
  output logic [2:0] space_three,
  output logic [2:0] final_bar,
  output logic       last_symbol,
  output logic       bad_input,
  output logic       sym_valid,
  input  logic       sym_ready
);
  import c128_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  c128_front u_front (
    .clk        (clk),
    .rst        (rst),
    .character  (character),
    .last_char  (last_char),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  c128_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .codeword    (codeword),
    .bar_one     (bar_one),
    .space_one   (space_one),
    .bar_two     (bar_two),
    .space_two   (space_two),
    .bar_three   (bar_three),
    .space_three (space_three),
    .final_bar   (final_bar),
    .last_symbol (last_symbol),
    .bad_input   (bad_input),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready)
  );

endmodule

@@ rtl/c128_checker.sv @@
// port-level checks on the code 128 encoder result stream
// bound to code128_symbol_encoder; depends on c128_pkg
module c128_checker (
  input logic       clk,
  input logic       rst,
  input logic [6:0] codeword,
  input logic [2:0] final_bar,
  input logic       last_symbol,
  input logic       bad_input,
  input logic       sym_valid,
  input logic       sym_ready
);
  import c128_pkg::*;

  // an error result always closes the message
  assert property (@(posedge clk) disable iff (rst)
    sym_valid && bad_input |-> last_symbol && codeword == 7'd0)
    else $error("error result without end mark");

  // the closing bar only ever comes with the stop symbol
  assert property (@(posedge clk) disable iff (rst)
    sym_valid && final_bar != 3'd0 |-> codeword == CW_STOP && !bad_input)
    else $error("closing bar on a non-stop symbol");

  // stop symbol ends the message
  assert property (@(posedge clk) disable iff (rst)
    sym_valid && !bad_input && codeword == CW_STOP && final_bar != 3'd0
      |-> last_symbol)
    else $error("stop symbol without end mark");

  // a stalled result holds until transfer
  assert property (@(posedge clk) disable iff (rst)
    sym_valid && !sym_ready |=> sym_valid && $stable(codeword))
    else $error("result changed while stalled");

endmodule

bind code128_symbol_encoder c128_checker u_c128_checker (
  .clk         (clk),
  .rst         (rst),
  .codeword    (codeword),
  .final_bar   (final_bar),
  .last_symbol (last_symbol),
  .bad_input   (bad_input),
  .sym_valid   (sym_valid),
  .sym_ready   (sym_ready)
);

@@ dv/code128_symbol_encoder_test.sv @@
// self-checking testbench for the code 128 symbol encoder: directed messages, then random
// messages under varying backpressure, all checked against a behavioural predictor
// depends on c128_pkg and code128_symbol_encoder
`timescale 1ns / 1ps

module code128_symbol_encoder_test;
  import c128_pkg::*;

  typedef struct packed {
    logic [6:0] cw;
    logic [2:0] b1, s1, b2, s2, b3, s3;
    logic [2:0] tail;
    logic       fin;
    logic       bad;
  } symbol_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       fin;
    logic       typed;
  } stim_row_t;

  localparam int N_RANDOM = 208;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [7:0] DIG0 = 8'd48;
  localparam logic [7:0] DIG9 = 8'd57;
  localparam symbol_t ERR_SYMBOL = '{cw: 7'd0, b1: 3'd0, s1: 3'd0, b2: 3'd0, s2: 3'd0,
                                     b3: 3'd0, s3: 3'd0, tail: 3'd0, fin: 1'b1, bad: 1'b1};

  // element widths of each codeword, one nibble per bar or space
  localparam logic [23:0] WIDTHS [107] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
    24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
    24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
    24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
    24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
    24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
    24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
    24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
    24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
    24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
    24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
    24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
    24'h411131, 24'h211412, 24'h211214, 24'h211232, 24'h233111
  };

  // short messages covering each start set, switching, odd digit runs, errors
  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{8'd49, 1'b0, 1'b0}, '{8'd50, 1'b0, 1'b0}, '{8'd51, 1'b0, 1'b0}, '{8'd52, 1'b1, 1'b0},
    '{8'd49, 1'b0, 1'b0}, '{8'd50, 1'b1, 1'b0},
    '{8'd0, 1'b0, 1'b0}, '{8'd65, 1'b0, 1'b0}, '{8'd98, 1'b0, 1'b0}, '{8'd31, 1'b1, 1'b0},
    '{8'd49, 1'b0, 1'b0}, '{8'd50, 1'b0, 1'b0}, '{8'd51, 1'b0, 1'b0}, '{8'd52, 1'b0, 1'b0},
    '{8'd53, 1'b0, 1'b0}, '{8'd120, 1'b1, 1'b0},
    '{8'd255, 1'b0, 1'b1}, '{8'd122, 1'b0, 1'b0}, '{8'd57, 1'b1, 1'b0},
    '{8'd128, 1'b1, 1'b1},
    '{8'd127, 1'b1, 1'b0},
    '{8'd32, 1'b1, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] character = 8'd0;
  logic       last_char = 1'b0;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic       sym_ready = 1'b0;
  logic       sym_valid;
  symbol_t    got;

  symbol_t    pending_symbols [$];
  int         send_idle_pct = 23;
  int         recv_stall_pct = 77;
  int         mismatches = 0;
  int         symbols_seen = 0;
  int         chars_sent = 0;
  int         messages_sent = 0;
  int         aborts_sent = 0;
  int         quiet_cycles = 0;

  // predictor state
  logic [6:0] win [LOOKAHEAD];
  int         win_fill;
  set_t       cur_set;
  int         weight;
  int         checksum;
  bit         dropping;

  code128_symbol_encoder dut (
    .clk(clk), .rst(rst),
    .character(character), .last_char(last_char),
    .char_valid(char_valid), .char_ready(char_ready),
    .codeword(got.cw), .bar_one(got.b1), .space_one(got.s1), .bar_two(got.b2),
    .space_two(got.s2), .bar_three(got.b3), .space_three(got.s3),
    .final_bar(got.tail), .last_symbol(got.fin), .bad_input(got.bad),
    .sym_valid(sym_valid), .sym_ready(sym_ready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_digit(logic [6:0] c);
    return c >= DIG0[6:0] && c <= DIG9[6:0];
  endfunction

  function automatic set_t set_for(logic [6:0] c);
    return (c < CHR_SPACE) ? SET_A : SET_B;
  endfunction

  function automatic logic [6:0] switch_to(set_t s);
    return (s == SET_A) ? CW_SW_A : ((s == SET_B) ? CW_SW_B : CW_SW_C);
  endfunction

  function automatic int digit_run();
    int i;
    i = 0;
    while (i < win_fill && i < LOOKAHEAD && is_digit(win[i])) i++;
    return i;
  endfunction

  function automatic void clear_window();
    foreach (win[i]) win[i] = 7'd0;
    win_fill = 0;
    cur_set = SET_NONE;
    weight = 0;
    checksum = 0;
  endfunction

  function automatic void expect_symbol(symbol_t s);
    pending_symbols = {pending_symbols, s};
  endfunction

  function automatic void push_symbol(logic [6:0] cw);
    symbol_t s;
    logic [23:0] w;
    w = WIDTHS[cw];
    s.cw = cw;
    s.b1 = w[22:20];
    s.s1 = w[18:16];
    s.b2 = w[14:12];
    s.s2 = w[10:8];
    s.b3 = w[6:4];
    s.s3 = w[2:0];
    s.tail = (cw == CW_STOP) ? STOP_TAIL : 3'd0;
    s.fin = (cw == CW_STOP);
    s.bad = 1'b0;
    expect_symbol(s);
  endfunction

  function automatic void push_weighted(logic [6:0] cw);
    checksum = (checksum + int'(cw) * weight) % 103;
    weight = (weight + 1) % 103;
    push_symbol(cw);
  endfunction

  function automatic void shift_out(int k);
    for (int i = 0; i < LOOKAHEAD; i++) win[i] = (i + k < LOOKAHEAD) ? win[i + k] : 7'd0;
    win_fill = (win_fill > k) ? win_fill - k : 0;
  endfunction

  function automatic void encode_step();
    int run;
    logic [6:0] c0;
    run = digit_run();
    c0 = win[0];
    if (cur_set != SET_C && run >= 4) begin
      cur_set = SET_C;
      push_weighted(CW_SW_C);
    end else if (cur_set == SET_C) begin
      if (run >= 2) begin
        push_weighted(7'((c0 - DIG0[6:0]) * 10 + (win[1] - DIG0[6:0])));
        shift_out(2);
      end else begin
        cur_set = set_for(c0);
        push_weighted(switch_to(cur_set));
      end
    end else if (set_for(c0) != cur_set) begin
      cur_set = set_for(c0);
      push_weighted(switch_to(cur_set));
    end else begin
      if (cur_set == SET_A) push_weighted(c0 < CHR_SPACE ? c0 + CHR_AT : c0 - CHR_SPACE);
      else push_weighted(c0 - CHR_SPACE);
      shift_out(1);
    end
  endfunction

  // expected symbols for one accepted character
  function automatic void predict_char(logic [7:0] c, logic fin);
    int run;
    logic [6:0] start;
    if (dropping) begin
      if (fin) dropping = 1'b0;
      return;
    end
    if (c[7]) begin
      expect_symbol(ERR_SYMBOL);
      clear_window();
      dropping = !fin;
      return;
    end
    if (win_fill < LOOKAHEAD) begin
      win[win_fill] = c[6:0];
      win_fill++;
    end
    if (cur_set == SET_NONE && (win_fill >= LOOKAHEAD || fin)) begin
      run = digit_run();
      if (run >= 4 || (fin && run == win_fill)) cur_set = SET_C;
      else cur_set = set_for(win[0]);
      start = (cur_set == SET_A) ? CW_START_A : ((cur_set == SET_B) ? CW_START_B : CW_START_C);
      checksum = start % 103;
      weight = 1;
      push_symbol(start);
    end
    if (fin) begin
      while (win_fill > 0) encode_step();
      push_symbol(7'(checksum));
      push_symbol(CW_STOP);
      clear_window();
    end else begin
      while (win_fill >= LOOKAHEAD) encode_step();
    end
  endfunction

  task automatic send_char(logic [7:0] c, logic fin, bit typed);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    character <= c;
    last_char <= fin;
    char_valid <= 1'b1;
    do @(posedge clk); while (!char_ready);
    predict_char(c, fin);
    // error rows carry their result written out by hand
    if (typed) begin
      pending_symbols[$] = ERR_SYMBOL;
    end
    chars_sent++;
    if (fin) messages_sent++;
    if (c[7]) aborts_sent++;
  endtask

  function automatic logic [7:0] pick_char(int flavour);
    case (flavour)
      0:       return ($urandom_range(9) < 8) ? 8'($urandom_range(57, 48))
                                              : 8'($urandom_range(127));
      1:       return 8'($urandom_range(127, 32));
      2:       return ($urandom_range(1)) ? 8'($urandom_range(31)) : 8'($urandom_range(127));
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  task automatic send_message(int base);
    int len;
    int flavour;
    logic [7:0] c;
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 9) : $urandom_range(1, 8);
    flavour = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      // idling profile moves on by thirds of the random part
      case ((chars_sent - base) * 3 / N_RANDOM)
        0:       begin send_idle_pct = 23; recv_stall_pct = 77; end
        1:       begin send_idle_pct = 77; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      c = pick_char(flavour);
      if ($urandom_range(29) == 0) c = 8'($urandom_range(255, 128));
      send_char(c, i == len - 1, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    sym_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && sym_valid && sym_ready) begin
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected symbol %p", got);
      end else begin
        symbol_t want;
        want = pending_symbols.pop_front();
        if (got.cw !== want.cw || got.b1 !== want.b1 || got.s1 !== want.s1 ||
            got.b2 !== want.b2 || got.s2 !== want.s2 || got.b3 !== want.b3 ||
            got.s3 !== want.s3 || got.tail !== want.tail || got.fin !== want.fin ||
            got.bad !== want.bad) begin
          mismatches++;
          if (mismatches <= 10) $display("symbol mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((char_valid && char_ready) || (sym_valid && sym_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int base;
    clear_window();
    dropping = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) send_char(DIRECTED[i].chr, DIRECTED[i].fin,
                                                   DIRECTED[i].typed);
    // hold off until the encoder has drained everything
    char_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    base = chars_sent;
    while (chars_sent - base < N_RANDOM) send_message(base);
    // close any message left open by an abort so the stream ends cleanly
    if (dropping) send_char(8'd65, 1'b1, 1'b0);
    char_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d characters in %0d messages, %0d aborting bytes", chars_sent,
             messages_sent, aborts_sent);
    $display("checked %0d symbols, %0d mismatches", symbols_seen, mismatches);
    if (mismatches == 0 && pending_symbols.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ code128_symbol_encoder.f @@
rtl/c128_pkg.sv
rtl/c128_front.sv
rtl/c128_back.sv
rtl/code128_symbol_encoder.sv
rtl/c128_checker.sv
dv/code128_symbol_encoder_test.sv
